### rtl/record_stream_lcg_xor_decoder_defines.svh
// assertion helpers for the record stream decoder
`ifndef RECORD_STREAM_LCG_XOR_DECODER_DEFINES_SVH
`define RECORD_STREAM_LCG_XOR_DECODER_DEFINES_SVH

// clocked on clk_i, quiet while rst_ni is low
`define RSLXD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked on clk_i, checked during reset as well
`define RSLXD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/rslxd_pkg.sv
package rslxd_pkg;

  localparam int unsigned OFFSET_BITS_DEFAULT = 32;

  // 69069 mod 256: only the low key byte is ever used
  localparam logic [7:0] KEY_MUL_LOW = 8'hCD;
  localparam logic [7:0] MAGIC_FIRST = 8'h50;   // 'P'
  localparam logic [7:0] MAGIC_SECOND = 8'h45;  // 'E'
  localparam logic [31:0] MIN_FILE_SIZE = 32'd4;
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_NEWLINE = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  typedef enum logic [5:0] {
    PH_MAGIC0 = 6'b000001,
    PH_MAGIC1 = 6'b000010,
    PH_LEN_LO = 6'b000100,
    PH_LEN_HI = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_STOP   = 6'b100000
  } phase_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       invalid;
    logic       last;
  } result_t;

endpackage

### rtl/record_stream_lcg_xor_decoder.sv
// record stream xor decoder
// input channel: one file byte per beat (in_byte_i, file_last_i on the final
//   byte), in_valid_i / in_ready_o
// config channel: cfg_valid_i / cfg_ready_o carries total_size_i, the byte
//   length of the next file; always ready, write only while idle
// output channel: out_valid_o / out_ready_i with kind_o, out_byte_o,
//   invalid_input_o and run_last_o; an input byte causes zero to three
//   results, run_last_o marks the last one of that byte
// latency: a byte's first result is presented the cycle after its beat
// throughput: one byte per cycle while each byte yields at most one result and
//   the receiver takes every result; a byte that yields more results holds the
//   input side while the single output port drains the three-entry result register
// the input side takes a new beat while the final pending result is being
//   taken, so back-to-back bytes flow without bubbles
// a stalled receiver holds all pending results and the input side waits
// reset clears the parser to expect the first magic byte and total_size to 0
// after each summary beat the parser returns to its reset state
`include "record_stream_lcg_xor_decoder_defines.svh"

module record_stream_lcg_xor_decoder #(
  parameter int unsigned OFFSET_BITS = rslxd_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] total_size_i,
  // file bytes in
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        file_last_i,
  // results out
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic        invalid_input_o,
  output logic        run_last_o
);
  import rslxd_pkg::*;

  // compare width covers offset + 1 + 16-bit length against a 32-bit size
  localparam int unsigned CMP_W = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 2;

  logic [31:0]            total_q;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  phase_e                 phase_q, phase_d;
  logic [7:0]             key_q, key_d;
  logic [15:0]            left_q, left_d;
  logic [7:0]             len_lo_q, len_lo_d;
  logic                   rej_q, rej_d;

  result_t                res_q [3];
  result_t                res_d [3];
  result_t                new_res [3];
  logic [1:0]             cnt_q, cnt_d;
  logic [1:0]             new_cnt;

  logic                   in_fire, out_fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_fire    = out_valid_o && out_ready_i;

  assign kind_o          = res_q[0].kind;
  assign out_byte_o      = res_q[0].data;
  assign invalid_input_o = res_q[0].invalid;
  assign run_last_o      = res_q[0].last;

  // per-byte parse step: wide offset adds and compares, one 8x8 multiply
  always_comb begin
    logic [CMP_W-1:0] off_x;
    logic [CMP_W-1:0] tot_x;
    logic [CMP_W-1:0] off_p1;
    logic [15:0]      len;
    logic [15:0]      prod;
    phase_e           ph;
    logic             inv;

    off_x  = CMP_W'(off_q);
    tot_x  = CMP_W'(total_q);
    off_p1 = off_x + CMP_W'(1);
    len    = {in_byte_i, len_lo_q};
    prod   = {8'h00, key_q} * {8'h00, KEY_MUL_LOW};
    inv    = 1'b0;

    phase_d  = phase_q;
    key_d    = key_q;
    left_d   = left_q;
    len_lo_d = len_lo_q;
    rej_d    = rej_q;
    new_cnt  = 2'd0;
    for (int i = 0; i < 3; i++) begin
      new_res[i] = '{kind: KIND_DATA, data: 8'h00, invalid: 1'b0, last: 1'b0};
    end

    // bytes past the declared size end the parse
    ph = phase_q;
    if ((off_x >= tot_x) && (phase_q != PH_MAGIC0)) begin
      ph = PH_STOP;
    end

    case (ph)
      PH_MAGIC0: begin
        if ((total_q < MIN_FILE_SIZE) || (in_byte_i != MAGIC_FIRST)) begin
          rej_d   = 1'b1;
          phase_d = PH_STOP;
        end else begin
          phase_d = PH_MAGIC1;
        end
      end
      PH_MAGIC1: begin
        if (in_byte_i != MAGIC_SECOND) begin
          rej_d   = 1'b1;
          phase_d = PH_STOP;
        end else begin
          phase_d = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        if (off_p1 >= tot_x) begin
          phase_d = PH_STOP;
        end else begin
          len_lo_d = in_byte_i;
          key_d    = off_q[7:0] | 8'h01;
          phase_d  = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        if ((off_p1 + CMP_W'(len)) > tot_x) begin
          phase_d = PH_STOP;
        end else if (len == 16'd0) begin
          new_res[new_cnt] = '{kind: KIND_NEWLINE, data: NEWLINE_BYTE,
                               invalid: 1'b0, last: 1'b0};
          new_cnt = new_cnt + 2'd1;
          phase_d = PH_LEN_LO;
        end else begin
          left_d  = len;
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        key_d = prod[7:0];
        new_res[new_cnt] = '{kind: KIND_DATA, data: in_byte_i ^ prod[7:0],
                             invalid: 1'b0, last: 1'b0};
        new_cnt = new_cnt + 2'd1;
        left_d  = left_q - 16'd1;
        if (left_q == 16'd1) begin
          new_res[new_cnt] = '{kind: KIND_NEWLINE, data: NEWLINE_BYTE,
                               invalid: 1'b0, last: 1'b0};
          new_cnt = new_cnt + 2'd1;
          phase_d = PH_LEN_LO;
        end else begin
          phase_d = PH_DATA;
        end
      end
      default: begin
        phase_d = PH_STOP;
      end
    endcase

    off_d = off_q + OFFSET_BITS'(1);

    // summary on the file's final byte, then back to the reset state
    if (file_last_i) begin
      inv = rej_d || (phase_d == PH_MAGIC0) || (phase_d == PH_MAGIC1);
      new_res[new_cnt] = '{kind: KIND_SUMMARY, data: 8'h00,
                           invalid: inv, last: 1'b0};
      new_cnt  = new_cnt + 2'd1;
      off_d    = '0;
      phase_d  = PH_MAGIC0;
      key_d    = 8'h00;
      left_d   = 16'd0;
      len_lo_d = 8'h00;
      rej_d    = 1'b0;
    end

    if (new_cnt != 2'd0) begin
      new_res[new_cnt - 2'd1].last = 1'b1;
    end
  end

  // result register: fresh results load at the head, otherwise shift on a taken beat
  always_comb begin
    res_d = res_q;
    cnt_d = cnt_q;
    if (in_fire) begin
      res_d = new_res;
      cnt_d = new_cnt;
    end else if (out_fire) begin
      res_d[0] = res_q[1];
      res_d[1] = res_q[2];
      cnt_d    = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      off_q    <= '0;
      phase_q  <= PH_MAGIC0;
      key_q    <= '0;
      left_q   <= '0;
      len_lo_q <= '0;
      rej_q    <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        total_q <= total_size_i;
      end
      if (in_fire) begin
        off_q    <= off_d;
        phase_q  <= phase_d;
        key_q    <= key_d;
        left_q   <= left_d;
        len_lo_q <= len_lo_d;
        rej_q    <= rej_d;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // a stalled head result keeps the pending count
  `RSLXD_ASSERT(a_stall_holds_count, out_valid_o && !out_ready_i |=> $stable(cnt_q), "pending count moved under stall")
  // a summary is always the final result of its byte
  `RSLXD_ASSERT(a_summary_is_last, out_valid_o && (kind_o == KIND_SUMMARY) |-> run_last_o, "summary without run_last")
  // the final file byte leaves a summary pending and a cleared offset
  `RSLXD_ASSERT(a_last_resets, in_fire && file_last_i |=> (cnt_q != 2'd0) && (off_q == '0) && (phase_q == PH_MAGIC0), "file end did not restart parser")
  // a byte taken after the parse stopped yields nothing unless it ends the file
  `RSLXD_ASSERT(a_stop_silent, in_fire && (phase_q == PH_STOP) && !file_last_i |=> cnt_q == 2'd0, "output after parse stop")

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rslxd_pkg::*;

  localparam int OFFSET_W = OFFSET_BITS_DEFAULT;
  localparam int unsigned KEY_STEP = 69069;   // key multiplier, only the low byte survives
  localparam int CYCLE_LIMIT = 200000;        // far above the slowest correct run
  localparam int RANDOM_BYTES = 180;
  localparam int SETTLE_CYCLES = 4;           // idle margin after the last pending result drains
  localparam int REPORT_MAX = 10;

  typedef logic [7:0] byte_q_t[$];

  // dut signals, all inputs known from time zero
  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] total_size_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i = '0;
  logic        file_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  out_byte_o;
  logic        invalid_input_o;
  logic        run_last_o;

  // idle odds in percent for the byte sender and the result receiver
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // run bookkeeping
  int cycle_count = 0;
  int mismatch_count = 0;
  int results_checked = 0;
  int bytes_sent = 0;
  int files_sent = 0;

  // decoder model state, starts at its reset values
  logic [31:0]         file_size = '0;
  logic [OFFSET_W-1:0] next_offset = '0;
  phase_e              parse_ph = PH_MAGIC0;
  logic [7:0]          key_byte = '0;
  logic [15:0]         record_left = '0;
  logic [7:0]          length_lo = '0;
  logic                bad_header = 1'b0;

  // results predicted but not yet seen, oldest first
  result_t pending_results[$];

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  record_stream_lcg_xor_decoder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .total_size_i    (total_size_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_byte_i       (in_byte_i),
    .file_last_i     (file_last_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .out_byte_o      (out_byte_o),
    .invalid_input_o (invalid_input_o),
    .run_last_o      (run_last_o)
  );

  // decode one accepted file byte and queue the results it causes
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    longint unsigned off;
    longint unsigned rec_len;
    longint unsigned size;
    logic [31:0]     prod;
    logic            inv;
    result_t         caused[$];
    off = 64'(next_offset);
    size = 64'(file_size);
    // past the end of the file nothing more is parsed
    if (off >= size && parse_ph != PH_MAGIC0) parse_ph = PH_STOP;
    case (parse_ph)
      PH_MAGIC0: begin
        if (file_size < MIN_FILE_SIZE || b != MAGIC_FIRST) begin
          bad_header = 1'b1;
          parse_ph = PH_STOP;
        end else begin
          parse_ph = PH_MAGIC1;
        end
      end
      PH_MAGIC1: begin
        if (b != MAGIC_SECOND) begin
          bad_header = 1'b1;
          parse_ph = PH_STOP;
        end else begin
          parse_ph = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        // no room left for a full length field
        if (off + 64'd1 >= size) begin
          parse_ph = PH_STOP;
        end else begin
          length_lo = b;
          key_byte = next_offset[7:0] | 8'h01;
          parse_ph = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        rec_len = 64'({b, length_lo});
        if (off + 64'd1 + rec_len > size) begin
          // record overruns the file: silent stop
          parse_ph = PH_STOP;
        end else if (rec_len == 64'd0) begin
          caused.push_back('{KIND_NEWLINE, NEWLINE_BYTE, 1'b0, 1'b0});
          parse_ph = PH_LEN_LO;
        end else begin
          record_left = rec_len[15:0];
          parse_ph = PH_DATA;
        end
      end
      PH_DATA: begin
        prod = 32'(key_byte) * KEY_STEP;
        key_byte = prod[7:0];
        caused.push_back('{KIND_DATA, b ^ key_byte, 1'b0, 1'b0});
        record_left = record_left - 16'd1;
        if (record_left == 16'd0) begin
          caused.push_back('{KIND_NEWLINE, NEWLINE_BYTE, 1'b0, 1'b0});
          parse_ph = PH_LEN_LO;
        end
      end
      default: begin
        parse_ph = PH_STOP;
      end
    endcase
    next_offset = next_offset + OFFSET_W'(1);
    if (last) begin
      // a file that never got past its magic is invalid too
      inv = bad_header || parse_ph == PH_MAGIC0 || parse_ph == PH_MAGIC1;
      caused.push_back('{KIND_SUMMARY, 8'h00, inv, 1'b0});
      next_offset = '0;
      parse_ph = PH_MAGIC0;
      key_byte = '0;
      record_left = '0;
      length_lo = '0;
      bad_header = 1'b0;
    end
    if (caused.size() > 0) caused[caused.size() - 1].last = 1'b1;
    foreach (caused[i]) pending_results.push_back(caused[i]);
  endfunction

  function automatic void report_mismatch(input string what, input result_t want,
                                          input result_t got);
    if (mismatch_count < REPORT_MAX) begin
      $display("%s at cycle %0d: expected kind %0d byte %02h invalid %0b last %0b",
               what, cycle_count, want.kind, want.data, want.invalid, want.last);
      $display("    got kind %0d byte %02h invalid %0b last %0b",
               got.kind, got.data, got.invalid, got.last);
    end
    mismatch_count++;
  endfunction

  // result checking first, then register writes and byte beats feed the model;
  // one process keeps the expectation queue free of ordering races
  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{kind_e'(kind_o), out_byte_o, invalid_input_o, run_last_o};
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind || got.data !== want.data ||
              got.invalid !== want.invalid || got.last !== want.last) begin
            report_mismatch("wrong result", want, got);
          end
        end
        results_checked++;
      end
      if (cfg_valid_i && cfg_ready_o) file_size = total_size_i;
      if (in_valid_i && in_ready_o) decode_byte(in_byte_i, file_last_i);
    end
  end

  // receiver stalls at the current odds
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("run stopped at the cycle limit of %0d", CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // one byte beat, with a random gap ahead of it; valid stays up afterwards
  // so the next byte can follow back to back
  task automatic send_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    file_last_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  // stream a whole file, file_last on its final byte; pause_at >= 0 holds
  // the sender at that byte until every pending result has drained
  task automatic send_file(input byte_q_t data, input int pause_at);
    foreach (data[i]) begin
      if (i == pause_at) wait_idle();
      send_byte(data[i], i == data.size() - 1);
    end
    files_sent++;
  endtask

  // drop valid and wait for the decoder to go quiet; the first edge lets the
  // checker see any beat taken in this step
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    total_size_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // magic and minimum size checks, size register at both extremes
  task automatic test_header_checks();
    byte_q_t data;
    set_idling(26, 84);
    // size below the minimum rejects even a correct first magic byte
    wait_idle();
    write_size(32'h0000_0000);
    data = {MAGIC_FIRST};
    send_file(data, -1);
    // wrong first magic byte
    wait_idle();
    write_size(32'hFFFF_FFFF);
    data = {MAGIC_FIRST ^ 8'h01, MAGIC_SECOND};
    send_file(data, -1);
    // wrong second magic byte
    wait_idle();
    data = {MAGIC_FIRST, 8'h00};
    send_file(data, -1);
    // file ends after the first magic byte
    wait_idle();
    data = {MAGIC_FIRST};
    send_file(data, -1);
  endtask

  // record parsing corner cases with a stalling receiver
  task automatic test_record_edges();
    byte_q_t data;
    set_idling(26, 84);
    // empty record, one-byte record, then a lone byte where a length should go
    wait_idle();
    write_size(32'd8);
    data = {MAGIC_FIRST, MAGIC_SECOND, 8'h00, 8'h00, 8'h01, 8'h00, 8'h7F, 8'h33};
    send_file(data, -1);
    // record of all-ones and all-zeros bytes, then one overrunning the size,
    // then a byte past the size that carries file_last
    wait_idle();
    write_size(32'd9);
    data = {MAGIC_FIRST, MAGIC_SECOND, 8'h02, 8'h00, 8'hFF, 8'h00,
            8'h05, 8'h00, 8'hBB, 8'h5A};
    send_file(data, -1);
  endtask

  // mostly well formed files with random records, some damaged headers,
  // some noise, and size registers that disagree with the stream
  task automatic test_random_files();
    byte_q_t     data;
    logic [31:0] size;
    int unsigned pick;
    int unsigned len;
    int          pause_at;
    int          start_bytes;
    bit          paused;
    paused = 1'b0;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      // idling pattern follows progress through the random part
      if (bytes_sent - start_bytes < RANDOM_BYTES / 3) set_idling(26, 84);
      else if (bytes_sent - start_bytes < 2 * RANDOM_BYTES / 3) set_idling(84, 26);
      else set_idling(0, 0);
      data = {};
      pick = $urandom_range(99);
      if (pick < 75) begin
        data = {MAGIC_FIRST, MAGIC_SECOND};
        repeat ($urandom_range(4, 1)) begin
          // short records mostly, now and then a longer one
          len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(6, 0);
          data.push_back(len[7:0]);
          data.push_back(len[15:8]);
          repeat (len) data.push_back(8'($urandom_range(255)));
        end
        size = data.size();
        case ($urandom_range(9))
          0: size = size - $urandom_range(4, 1);   // last record overruns
          1: size = size + $urandom_range(3, 1);   // stream ends early
          default: ;
        endcase
      end else if (pick < 88) begin
        data = {$urandom_range(1) ? MAGIC_FIRST : 8'($urandom_range(255)),
                $urandom_range(1) ? MAGIC_SECOND : 8'($urandom_range(255))};
        repeat ($urandom_range(4)) data.push_back(8'($urandom_range(255)));
        size = $urandom_range(1) ? data.size() : $urandom_range(5);
      end else begin
        repeat ($urandom_range(8, 1)) data.push_back(8'($urandom_range(255)));
        size = $urandom_range(1) ? $urandom_range(10) : $urandom;
      end
      // hold the sender once in the middle of a file until all results are out
      pause_at = -1;
      if (!paused && data.size() >= 8) begin
        pause_at = data.size() / 2;
        paused = 1'b1;
      end
      wait_idle();
      write_size(size);
      send_file(data, pause_at);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_header_checks();
    test_record_edges();
    test_random_files();
    wait_idle();
    $display("streamed %0d files, %0d bytes; %0d results checked", files_sent,
             bytes_sent, results_checked);
    $display("covered header rejects, empty and overrunning records, bytes past the size");
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
